// ----- src/sharp_pkg.sv -----
// shared types and constants for the 3x3 sharpen filter
package sharp_pkg;

  localparam int unsigned IMG_W_W    = 12;  // width register
  localparam int unsigned IMG_H_W    = 13;  // height register
  localparam int unsigned CFG_DATA_W = 13;  // widest register
  localparam int unsigned COL_W      = 11;  // reported column
  localparam int unsigned ROW_W      = 12;  // row counter and reported row
  localparam int unsigned MIN_SIZE   = 3;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;

  // output buffer
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] pix_t;   // blue, green, red from msb down

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  // two line entries kept together at one address
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_pair_t;

  // per-beat side information travelling beside the window
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } meta_t;

  typedef struct packed {
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

endpackage

// ----- src/sharp_cell.sv -----
// one window cell: holds a pixel and hands it to its left neighbour
module sharp_cell import sharp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  pix_t pix_i,
  output pix_t pix_o
);

  pix_t pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

// ----- src/sharp_line_ram.sv -----
// line buffer memory, one write and one registered read port
module sharp_line_ram import sharp_pkg::*; #(
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output line_pair_t               rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  line_pair_t               wdata_i
);

  line_pair_t mem [DEPTH];
  line_pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/sharp_kernel.sv -----
// sharpen kernel for one colour channel, one register stage then clamp
module sharp_kernel import sharp_pkg::*; (
  input  logic  clk_i,
  input  chan_t centre_i,
  input  chan_t nbr_i [8],
  output chan_t res_o
);

  logic [11:0]        nine_d, nine_q;
  logic [10:0]        neg_d, neg_q;
  logic signed [12:0] diff;

  always_comb begin
    nine_d = {1'b0, centre_i, 3'b000} + 12'(centre_i);
    neg_d  = '0;
    for (int k = 0; k < 8; k++) begin
      neg_d = neg_d + 11'(nbr_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    nine_q <= nine_d;
    neg_q  <= neg_d;
  end

  // clamp to a byte
  always_comb begin
    diff = $signed({1'b0, nine_q}) - $signed({2'b00, neg_q});
    if (diff < 0) begin
      res_o = '0;
    end else if (diff > 13'sd255) begin
      res_o = 8'hff;
    end else begin
      res_o = diff[7:0];
    end
  end

endmodule

// ----- src/sharp_out_fifo.sv -----
// output buffer holding finished result beats
module sharp_out_fifo import sharp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  res_t               data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output res_t               data_o,
  output logic [FIFO_CW-1:0] count_o
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;

  assign pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- src/sharpen_3x3_rgb_filter.sv -----
// top level of the 3x3 sharpen filter on an rgb pixel stream
// an accepted beat passes the line memory read, the window cells and the kernel register,
// then its result is written to the output buffer and shown at out_*; one pixel per clock
// sustained while in_stall_o is low, the line memory read and the window shift both run once per beat
// output buffer of eight beats; input stalls when buffered plus in-flight results fill it
// reset: width 640, height 480, counters and window cleared, line memory left uncleared
module sharpen_3x3_rgb_filter import sharp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic [COL_W-1:0]      out_column_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic                  last_pixel_o
);

  // column counter and line address width, and a width wide enough for both
  // the register and the largest supported line length
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [IMG_W_W-1:0] img_width_q;
  logic [IMG_H_W-1:0] img_height_q;
  logic               cfg_hit;

  always_comb begin
    unique case (cfg_reg_e'(cfg_idx_i))
      CFG_WIDTH:  cfg_hit = cfg_we_i;
      CFG_HEIGHT: cfg_hit = cfg_we_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= IMG_W_W'(WIDTH_RST);
      img_height_q <= IMG_H_W'(HEIGHT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WIDTH:  img_width_q  <= cfg_wdata_i[IMG_W_W-1:0];
        CFG_HEIGHT: img_height_q <= cfg_wdata_i;
      endcase
    end
  end

  // effective frame size, saturated into the supported range
  logic [EW-1:0]      w_ext, w_eff;
  logic [IMG_H_W-1:0] h_eff;

  always_comb begin
    w_ext = EW'(img_width_q);
    if (w_ext < EW'(MIN_SIZE)) begin
      w_eff = EW'(MIN_SIZE);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (img_height_q < IMG_H_W'(MIN_SIZE)) begin
      h_eff = IMG_H_W'(MIN_SIZE);
    end else if (img_height_q > IMG_H_W'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // raster position of the incoming pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    col_q, col_d, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  logic             col_end, row_end;
  logic             in_accept;
  meta_t            meta0;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    // positions are clipped to the frame in case the size shrank under them
    col_eff = (EW'(col_q) >= w_eff) ? CW'(w_eff - 1'b1) : col_q;
    row_eff = (IMG_H_W'(row_q) >= h_eff) ? ROW_W'(h_eff - 1'b1) : row_q;
    col_end = (EW'(col_eff) == w_eff - 1'b1);
    row_end = (IMG_H_W'(row_eff) == h_eff - 1'b1);

    col_d = col_eff + 1'b1;
    row_d = row_eff;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_eff + 1'b1;
    end

    // result centred one up and one left once the window is full
    meta0.emit = (col_eff >= CW'(2)) && (row_eff >= ROW_W'(2));
    meta0.last = col_end && row_end;
    meta0.col  = COL_W'(col_eff - 1'b1);
    meta0.row  = row_eff - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      // any register write restarts the frame
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line memory read returns, pixel and position wait beside it
  // ---------------------------------------------------------------------------
  logic          p1_valid_q;
  meta_t         p1_meta_q;
  pix_t          p1_pix_q;
  logic [CW-1:0] p1_addr_q;
  line_pair_t    line_rdata, line_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p1_meta_q <= meta0;
      p1_pix_q  <= {in_blue_i, in_green_i, in_red_i};
      p1_addr_q <= col_eff;
    end
  end

  // the row above moves up to the older line, the new pixel becomes the newer
  assign line_wdata.older = line_rdata.newer;
  assign line_wdata.newer = p1_pix_q;

  // the same address comes round again only a full line later, well after
  // the write-back in the cycle after the read
  sharp_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .re_i    (in_accept),
    .raddr_i (col_eff),
    .rdata_o (line_rdata),
    .we_i    (p1_valid_q),
    .waddr_i (p1_addr_q),
    .wdata_i (line_wdata)
  );

  // ---------------------------------------------------------------------------
  // 3x3 window: three rows of three cells, each row shifting leftward
  // cell k sits at row k/3, column k%3; the right column takes the new data
  // ---------------------------------------------------------------------------
  pix_t win [9];
  pix_t row_src [3];

  assign row_src[0] = line_rdata.older;
  assign row_src[1] = line_rdata.newer;
  assign row_src[2] = p1_pix_q;

  for (genvar k = 0; k < 9; k++) begin : g_cell
    if ((k % 3) == 2) begin : g_right
      sharp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (p1_valid_q),
        .pix_i   (row_src[k / 3]),
        .pix_o   (win[k])
      );
    end else begin : g_inner
      sharp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (p1_valid_q),
        .pix_i   (win[k + 1]),
        .pix_o   (win[k])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2 and 3: position follows the window and the kernel register
  // ---------------------------------------------------------------------------
  logic  p2_emit_q, p3_emit_q;
  meta_t p2_meta_q, p3_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_emit_q <= 1'b0;
      p3_emit_q <= 1'b0;
    end else begin
      p2_emit_q <= p1_valid_q && p1_meta_q.emit;
      p3_emit_q <= p2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_meta_q <= p1_meta_q;
    p3_meta_q <= p2_meta_q;
  end

  // one kernel per colour, centre weighted nine, neighbours minus one
  chan_t ch_res [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    chan_t nbr [8];

    for (genvar j = 0; j < 8; j++) begin : g_nbr
      assign nbr[j] = win[(j < 4) ? j : j + 1][8*ch +: 8];
    end

    sharp_kernel u_kernel (
      .clk_i    (clk_i),
      .centre_i (win[4][8*ch +: 8]),
      .nbr_i    (nbr),
      .res_o    (ch_res[ch])
    );
  end

  // ---------------------------------------------------------------------------
  // output buffer and flow control
  // ---------------------------------------------------------------------------
  res_t               push_data, head;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   slots_used;
  logic               out_pop;

  assign push_data.red   = ch_res[0];
  assign push_data.green = ch_res[1];
  assign push_data.blue  = ch_res[2];
  assign push_data.col   = p3_meta_q.col;
  assign push_data.row   = p3_meta_q.row;
  assign push_data.last  = p3_meta_q.last;

  assign out_pop = out_valid_o && !out_stall_i;

  sharp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (p3_emit_q),
    .data_i  (push_data),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .data_o  (head),
    .count_o (fifo_cnt)
  );

  // every result still in the pipe already holds a slot in the buffer
  assign slots_used = (FIFO_CW + 1)'(fifo_cnt)
                    + (FIFO_CW + 1)'(p1_valid_q && p1_meta_q.emit)
                    + (FIFO_CW + 1)'(p2_emit_q)
                    + (FIFO_CW + 1)'(p3_emit_q);
  assign in_stall_o = (slots_used >= (FIFO_CW + 1)'(FIFO_DEPTH));

  assign out_red_o    = head.red;
  assign out_green_o  = head.green;
  assign out_blue_o   = head.blue;
  assign out_column_o = head.col;
  assign out_row_o    = head.row;
  assign last_pixel_o = head.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an accepted interior pixel reaches the buffer through the p1, p2 and p3 registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && meta0.emit) |-> ##3 p3_emit_q)
    else $error("interior beat did not reach the output buffer");

  // the slot accounting must keep the buffer from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_emit_q |-> ((fifo_cnt != FIFO_CW'(FIFO_DEPTH)) || out_pop))
    else $error("output buffer overflow");

  // the column counter stays inside the current line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (EW'(col_q) < w_eff))
    else $error("column counter outside line");

endmodule
